// File: hw/rtl/trapezoidal_joint_trajectory_macros.svh
// Assertion macros shared by the trapezoidal joint trajectory RTL.
`ifndef TRAPEZOIDAL_JOINT_TRAJECTORY_MACROS_SVH
`define TRAPEZOIDAL_JOINT_TRAJECTORY_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TJT_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tjt same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TJT_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tjt next-cycle check failed");

`endif

// File: hw/rtl/tjt_pkg.sv
// Types, constants and helper functions of the trapezoidal joint trajectory block.
`default_nettype none
package tjt_pkg;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_READ = 11'b000_0000_0010,
		S_BRK1 = 11'b000_0000_0100,
		S_BRK2 = 11'b000_0000_1000,
		S_ACC  = 11'b000_0001_0000,
		S_VINT = 11'b000_0010_0000,
		S_VUPD = 11'b000_0100_0000,
		S_AMUL = 11'b000_1000_0000,
		S_POS  = 11'b001_0000_0000,
		S_SNAP = 11'b010_0000_0000,
		S_OUT  = 11'b100_0000_0000
	} state_t;

	localparam logic [2:0] REG_VEL_LIMIT = 3'd0;
	localparam logic [2:0] REG_ACC_LIMIT = 3'd1;
	localparam logic [2:0] REG_RATE      = 3'd2;
	localparam logic [2:0] REG_PERIOD    = 3'd3;
	localparam logic [2:0] REG_MIN_DEG   = 3'd4;
	localparam logic [2:0] REG_MAX_DEG   = 3'd5;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_RESET = 1'b1;

	localparam logic [31:0] POS_EPS        = 32'd1;
	localparam logic [32:0] SNAP_ERR       = 33'd10;
	localparam logic [31:0] SNAP_VEL       = 32'd1048;
	localparam logic [26:0] DEG2RAD_Q32    = 27'd74961321;
	localparam logic [15:0] DEFAULT_RATE   = 16'd1000;
	localparam logic [31:0] DEFAULT_PERIOD = 32'd4294967;
	localparam logic signed [10:0] MARGIN_DEG = 11'sd5;

	localparam logic [30:0] RST_VEL_LIMIT = 31'd3294199;
	localparam logic [30:0] RST_ACC_LIMIT = 31'd13176795;
	localparam logic [15:0] RST_RATE      = 16'd1000;
	localparam logic [31:0] RST_PERIOD    = 32'd4294967;
	localparam logic [9:0]  RST_MIN_DEG   = 10'd0;
	localparam logic [9:0]  RST_MAX_DEG   = 10'd90;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
		logic signed [31:0] r;
		if (x > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
		else if (x < -34'sh0_8000_0000) r = 32'sh8000_0000;
		else r = x[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] deg_to_rad(input logic signed [10:0] d);
		logic [10:0] m;
		logic [37:0] p;
		logic [31:0] r;
		m = d[10] ? (~d + 11'd1) : d;
		p = 38'(m) * 38'(DEG2RAD_Q32) + 38'd2048;
		r = {6'd0, p[37:12]};
		return d[10] ? (~r + 32'd1) : r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tjt_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
`default_nettype none
module tjt_mul (
	input  wire         clk,
	input  wire  [31:0] a,
	input  wire  [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule
`default_nettype wire

// File: hw/rtl/trapezoidal_joint_trajectory.sv
// Top level of the trapezoidal joint trajectory generator.
// One input beat is one control tick for one joint, or a command that clears every joint;
// each beat gives exactly one output beat. Per-joint angle, velocity and acceleration live
// in a JOINTS-deep state memory with a registered read; a joint becomes active on its
// first beat with valid feedback and is seeded from it. A tick with a valid target passes
// through the memory read (skipped when the same beat seeds the joint), five passes through
// the one shared 32x32 multiplier (two for the braking compare, then acceleration, velocity
// and angle integration), the position update and the snap check before the output register
// is loaded. Other beats go to the output register directly or after the memory read only.
// Input is accepted only while the sequencer is idle, so the next beat is accepted in the
// cycle after the load at the earliest. The output register holds a result until it is
// taken. No clearing pass is needed after reset: the active flags gate the store.
`default_nettype none
module trapezoidal_joint_trajectory #(
	parameter int JOINTS = 4
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// joint[1:0], target_angle[33:2], feedback_angle[65:34], zero pad
	input  wire  [71:0]  s_axis_tdata,
	// cmd[0], target_valid[1], feedback_valid[2]
	input  wire  [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// joint_out[1:0], angle_out[33:2], velocity_out[65:34], accel_out[97:66],
	// angle_error[129:98], zero pad
	output logic [135:0] m_axis_tdata,
	// out_valid[0], error_valid[1]
	output logic [1:0]   m_axis_tuser,
	input  wire          cfg_we,
	input  wire  [2:0]   cfg_index,
	input  wire  [31:0]  cfg_data
);

	`include "trapezoidal_joint_trajectory_macros.svh"

	localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	tjt_pkg::state_t state_q;

	logic [30:0] vel_limit_q, acc_limit_q;
	logic [15:0] rate_q;
	logic [31:0] period_q;
	logic [9:0]  min_deg_q, max_deg_q;
	logic signed [31:0] lo_q, hi_q;

	logic [JOINTS-1:0] active_q;
	logic [95:0] mem [JOINTS];
	logic [95:0] rdata_q;

	logic [1:0]  joint_q;
	logic signed [31:0] tgt_q, fb_q, ang_q, v_q, acc_q;
	logic tv_q, fv_q, hit_q;
	logic signed [32:0] e_q;
	logic [62:0] vv_q;
	logic dneg_q;

	logic [1:0] s_joint;
	logic [AW-1:0] s_addr, w_addr;
	logic accept, in_range, mem_we, out_load;

	logic [30:0] vl, al;
	logic [15:0] rate;
	logic [31:0] per, vl32;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	logic [31:0] vabs, ae, dvmag, r;
	logic [32:0] ae33, dvabs33;
	logic drive;
	logic signed [32:0] des, dv, ne;
	logic [32:0] nemag;
	logic [30:0] amag;
	logic [63:0] rsum;
	logic signed [33:0] vn, an;
	logic signed [31:0] vclamp, ca;
	logic snap;

	assign s_joint  = s_axis_tdata[1:0];
	assign s_addr   = AW'(s_joint);
	assign w_addr   = AW'(joint_q);
	assign in_range = 32'(s_joint) < 32'(JOINTS);
	assign s_axis_tready = (state_q == tjt_pkg::S_IDLE);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign mem_we   = (state_q == tjt_pkg::S_OUT) && hit_q;
	assign out_load = (state_q == tjt_pkg::S_OUT) && (!m_axis_tvalid || m_axis_tready);

	assign vl   = (vel_limit_q == 31'd0) ? 31'd1 : vel_limit_q;
	assign al   = (acc_limit_q == 31'd0) ? 31'd1 : acc_limit_q;
	assign rate = (rate_q == 16'd0) ? tjt_pkg::DEFAULT_RATE : rate_q;
	assign per  = (period_q == 32'd0) ? tjt_pkg::DEFAULT_PERIOD : period_q;
	assign vl32 = {1'b0, vl};

	always_comb begin
		vabs    = v_q[31] ? (~v_q + 32'd1) : v_q;
		ae33    = e_q[32] ? (~e_q + 33'd1) : e_q;
		ae      = ae33[31:0];
		drive   = (ae > tjt_pkg::POS_EPS) && (prod[62:0] > vv_q);
		des     = drive ? (e_q[32] ? -$signed({2'b00, vl}) : $signed({2'b00, vl})) : 33'sd0;
		dv      = des - $signed({v_q[31], v_q});
		dvabs33 = dv[32] ? (~dv + 33'd1) : dv;
		dvmag   = dvabs33[31:0];
		amag    = (prod > {33'd0, al}) ? al : prod[30:0];
		rsum    = prod + 64'h8000_0000;
		r       = rsum[63:32];
		vn      = acc_q[31] ? ($signed({{2{v_q[31]}}, v_q}) - $signed({2'b00, r}))
		                    : ($signed({{2{v_q[31]}}, v_q}) + $signed({2'b00, r}));
		if (vn > $signed({3'b000, vl})) vclamp = $signed(vl32);
		else if (vn < -$signed({3'b000, vl})) vclamp = -$signed(vl32);
		else vclamp = vn[31:0];
		an      = v_q[31] ? ($signed({{2{ang_q[31]}}, ang_q}) - $signed({2'b00, r}))
		                  : ($signed({{2{ang_q[31]}}, ang_q}) + $signed({2'b00, r}));
		ne      = $signed({tgt_q[31], tgt_q}) - $signed({ang_q[31], ang_q});
		nemag   = ne[32] ? (~ne + 33'd1) : ne;
		snap    = (!e_q[32] && (e_q != 33'sd0) && ne[32])
		       || (e_q[32] && !ne[32] && (ne != 33'sd0))
		       || ((nemag <= tjt_pkg::SNAP_ERR) && (vabs <= tjt_pkg::SNAP_VEL));
		ca      = ang_q;
		if (ca < lo_q) ca = lo_q;
		if (ca > hi_q) ca = hi_q;
	end

	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			tjt_pkg::S_BRK1: begin
				mul_a = vabs;
				mul_b = vabs;
			end
			tjt_pkg::S_BRK2: begin
				mul_a = ae;
				mul_b = {1'b0, al};
			end
			tjt_pkg::S_ACC: begin
				mul_a = dvmag;
				mul_b = {16'd0, rate};
			end
			tjt_pkg::S_VINT: begin
				mul_a = {1'b0, amag};
				mul_b = per;
			end
			tjt_pkg::S_AMUL: begin
				mul_a = vabs;
				mul_b = per;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	tjt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_limit_q <= tjt_pkg::RST_VEL_LIMIT;
			acc_limit_q <= tjt_pkg::RST_ACC_LIMIT;
			rate_q      <= tjt_pkg::RST_RATE;
			period_q    <= tjt_pkg::RST_PERIOD;
			min_deg_q   <= tjt_pkg::RST_MIN_DEG;
			max_deg_q   <= tjt_pkg::RST_MAX_DEG;
		end else if (cfg_we) begin
			case (cfg_index)
				tjt_pkg::REG_VEL_LIMIT: vel_limit_q <= cfg_data[30:0];
				tjt_pkg::REG_ACC_LIMIT: acc_limit_q <= cfg_data[30:0];
				tjt_pkg::REG_RATE:      rate_q      <= cfg_data[15:0];
				tjt_pkg::REG_PERIOD:    period_q    <= cfg_data;
				tjt_pkg::REG_MIN_DEG:   min_deg_q   <= cfg_data[9:0];
				tjt_pkg::REG_MAX_DEG:   max_deg_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= tjt_pkg::deg_to_rad($signed({min_deg_q[9], min_deg_q}) - tjt_pkg::MARGIN_DEG);
		hi_q <= tjt_pkg::deg_to_rad($signed({max_deg_q[9], max_deg_q}));
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[w_addr] <= {acc_q, v_q, ang_q};
		if (accept) rdata_q <= mem[s_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tjt_pkg::S_IDLE;
			active_q <= '0;
		end else begin
			case (state_q)
				tjt_pkg::S_IDLE: begin
					if (accept) begin
						if (s_axis_tuser[0] == tjt_pkg::CMD_RESET) begin
							active_q <= '0;
							state_q  <= tjt_pkg::S_OUT;
						end else if (in_range && active_q[s_addr]) begin
							state_q <= tjt_pkg::S_READ;
						end else if (in_range && s_axis_tuser[2]) begin
							active_q[s_addr] <= 1'b1;
							state_q <= s_axis_tuser[1] ? tjt_pkg::S_BRK1 : tjt_pkg::S_OUT;
						end else begin
							state_q <= tjt_pkg::S_OUT;
						end
					end
				end
				tjt_pkg::S_READ: state_q <= tv_q ? tjt_pkg::S_BRK1 : tjt_pkg::S_OUT;
				tjt_pkg::S_BRK1: state_q <= tjt_pkg::S_BRK2;
				tjt_pkg::S_BRK2: state_q <= tjt_pkg::S_ACC;
				tjt_pkg::S_ACC:  state_q <= tjt_pkg::S_VINT;
				tjt_pkg::S_VINT: state_q <= tjt_pkg::S_VUPD;
				tjt_pkg::S_VUPD: state_q <= tjt_pkg::S_AMUL;
				tjt_pkg::S_AMUL: state_q <= tjt_pkg::S_POS;
				tjt_pkg::S_POS:  state_q <= tjt_pkg::S_SNAP;
				tjt_pkg::S_SNAP: state_q <= tjt_pkg::S_OUT;
				tjt_pkg::S_OUT: begin
					if (out_load) state_q <= tjt_pkg::S_IDLE;
				end
				default: state_q <= tjt_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tjt_pkg::S_IDLE: begin
				if (accept) begin
					joint_q <= s_joint;
					tgt_q   <= s_axis_tdata[33:2];
					fb_q    <= s_axis_tdata[65:34];
					tv_q    <= s_axis_tuser[1];
					fv_q    <= s_axis_tuser[2];
					hit_q   <= (s_axis_tuser[0] == tjt_pkg::CMD_TICK) && in_range
					        && (active_q[s_addr] || s_axis_tuser[2]);
					ang_q   <= s_axis_tdata[65:34];
					v_q     <= 32'sd0;
					acc_q   <= 32'sd0;
				end
			end
			tjt_pkg::S_READ: begin
				ang_q <= rdata_q[31:0];
				v_q   <= rdata_q[63:32];
				acc_q <= rdata_q[95:64];
			end
			tjt_pkg::S_BRK1: e_q <= $signed({tgt_q[31], tgt_q}) - $signed({ang_q[31], ang_q});
			tjt_pkg::S_BRK2: vv_q <= prod[63:1];
			tjt_pkg::S_ACC:  dneg_q <= dv[32];
			tjt_pkg::S_VINT: acc_q <= dneg_q ? (~{1'b0, amag} + 32'd1) : {1'b0, amag};
			tjt_pkg::S_VUPD: v_q <= vclamp;
			tjt_pkg::S_POS:  ang_q <= tjt_pkg::sat32(an);
			tjt_pkg::S_SNAP: begin
				if (snap) begin
					ang_q <= tgt_q;
					v_q   <= 32'sd0;
					acc_q <= 32'sd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata[1:0]     <= joint_q;
			m_axis_tdata[135:130] <= 6'd0;
			if (hit_q) begin
				m_axis_tdata[33:2]   <= ca;
				m_axis_tdata[65:34]  <= v_q;
				m_axis_tdata[97:66]  <= acc_q;
				m_axis_tdata[129:98] <= fv_q
					? tjt_pkg::sat32($signed({{2{fb_q[31]}}, fb_q}) - $signed({{2{ca[31]}}, ca}))
					: 32'sd0;
				m_axis_tuser <= {fv_q, 1'b1};
			end else begin
				m_axis_tdata[129:2] <= '0;
				m_axis_tuser        <= 2'b00;
			end
		end
	end

	`TJT_ASSERT_NEXT(a_out_loaded, out_load, m_axis_tvalid)
	`TJT_ASSERT_SAME(a_write_active, mem_we, active_q[w_addr])
	`TJT_ASSERT_NEXT(a_reset_clears, accept && (s_axis_tuser[0] == tjt_pkg::CMD_RESET),
		active_q == '0)
	`TJT_ASSERT_SAME(a_vel_bounded, state_q == tjt_pkg::S_AMUL,
		(v_q <= $signed(vl32)) && (v_q >= -$signed(vl32)))

endmodule
`default_nettype wire
